@@ sv/dhks_pkg.sv @@
`default_nettype none
package dhks_pkg;
    localparam int TABLE_SIZE_DEF = 1021;
    localparam int KEY_WIDTH_DEF  = 64;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 10;
    localparam int COUNT_W  = 10;

    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_PRESENT  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ABSENT   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

    typedef struct packed {
        logic clr_step;   // write zero at the sweep address
        logic start;      // load key, begin modulo reduction
        logic red_step;   // one step of the digit-wise reduction
        logic rd;         // read table at probe position
        logic adv;        // advance probe position
        logic wr;         // write key at probe position
        logic ld_out;     // load result register
    } dhks_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic red_done;
        logic key_zero;
        logic hit;
        logic empty;
        logic exhausted;
    } dhks_sts_t;
endpackage
`default_nettype wire

@@ sv/dhks_datapath.sv @@
`default_nettype none
module dhks_datapath
    import dhks_pkg::*;
#(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF,
    parameter int KEY_WIDTH  = KEY_WIDTH_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire dhks_cmd_t             cmd,
    output dhks_sts_t                  sts,
    input  wire logic                  in_kind,
    input  wire logic [63:0]           in_key,
    input  wire logic [STATUS_W-1:0]   res_status,
    input  wire logic                  use_slot,
    output logic [STATUS_W-1:0]        out_status,
    output logic [SLOT_W-1:0]          out_slot,
    output logic [COUNT_W-1:0]         out_count,
    output logic                       kind_q,
    output logic                       full_load
);
    localparam int AW = $clog2(TABLE_SIZE);
    localparam int CW = $clog2(TABLE_SIZE + 1);
    localparam int RW = 16;
    localparam int DW = 16;
    localparam int ND = (KEY_WIDTH + DW - 1) / DW;
    localparam int DCW = $clog2(ND + 1);
    localparam int KPW = ND * DW;
    localparam logic [AW:0] TS = (AW+1)'(TABLE_SIZE);
    localparam logic [RW-1:0] M1 = RW'(TABLE_SIZE);
    localparam logic [RW-1:0] M2 = RW'(TABLE_SIZE - 1);
    localparam logic [31:0] RCP1 = 32'((64'd1 << 32) / 64'(TABLE_SIZE));
    localparam logic [31:0] RCP2 = 32'((64'd1 << 32) / 64'(TABLE_SIZE - 1));

    logic [KEY_WIDTH-1:0] mem [TABLE_SIZE];
    logic [KEY_WIDTH-1:0] key_reg, rd_reg;
    logic [KPW-1:0] kp_reg;
    logic [RW-1:0] rem1_reg, rem2_reg;
    logic [31:0] v1_reg, v2_reg, q1_reg, q2_reg;
    logic [DCW-1:0] dig_reg;
    logic ph_reg;
    logic [AW-1:0] pos_reg, inc_reg, clr_reg;
    logic [CW-1:0] n_reg, cnt_reg;
    logic kind_reg;
    logic [STATUS_W-1:0] st_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [COUNT_W-1:0] cntout_reg;

    logic [31:0] v1, v2;
    logic [63:0] prod1, prod2;
    logic [31:0] diff1, diff2;
    logic [RW-1:0] red1, red2;
    logic [AW:0] psum;
    logic [AW-1:0] pos_next;

    // Horner reduction of k, one 16-bit digit at a time, most significant first.
    // The first phase estimates the quotient with a reciprocal multiply; the estimate is
    // low by at most one, so the second phase needs a single compare and subtract.
    assign v1 = {rem1_reg, kp_reg[KPW-1 -: DW]};
    assign v2 = {rem2_reg, kp_reg[KPW-1 -: DW]};
    assign prod1 = 64'(v1) * 64'(RCP1);
    assign prod2 = 64'(v2) * 64'(RCP2);
    assign diff1 = v1_reg - 32'(48'(q1_reg) * 48'(M1));
    assign diff2 = v2_reg - 32'(48'(q2_reg) * 48'(M2));
    assign red1 = (diff1 >= 32'(M1)) ? RW'(diff1 - 32'(M1)) : RW'(diff1);
    assign red2 = (diff2 >= 32'(M2)) ? RW'(diff2 - 32'(M2)) : RW'(diff2);

    assign psum = {1'b0, pos_reg} + {1'b0, inc_reg};
    assign pos_next = (psum >= TS) ? AW'(psum - TS) : psum[AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
            cnt_reg <= '0;
            dig_reg <= '0;
            ph_reg  <= 1'b0;
            n_reg   <= '0;
        end
        else
        begin
            if (cmd.clr_step) clr_reg <= AW'(clr_reg + 1'b1);
            if (cmd.start)
            begin
                dig_reg <= '0;
                ph_reg  <= 1'b0;
            end
            else if (cmd.red_step)
            begin
                ph_reg <= ~ph_reg;
                if (ph_reg) dig_reg <= DCW'(dig_reg + 1'b1);
            end
            if (cmd.start) n_reg <= '0;
            else if (cmd.adv) n_reg <= CW'(n_reg + 1'b1);
            if (cmd.wr) cnt_reg <= CW'(cnt_reg + 1'b1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            key_reg  <= in_key[KEY_WIDTH-1:0];
            kp_reg   <= KPW'(KEY_WIDTH'(in_key[KEY_WIDTH-1:0] - 1'b1));
            kind_reg <= in_kind;
            rem1_reg <= '0;
            rem2_reg <= '0;
        end
        else if (cmd.red_step)
        begin
            if (!ph_reg)
            begin
                v1_reg <= v1;
                v2_reg <= v2;
                q1_reg <= prod1[63:32];
                q2_reg <= prod2[63:32];
            end
            else
            begin
                rem1_reg <= red1;
                rem2_reg <= red2;
                kp_reg   <= kp_reg << DW;
                if (dig_reg == DCW'(ND - 1))
                begin
                    pos_reg <= red1[AW-1:0];
                    inc_reg <= AW'(red2 + 1'b1);
                end
            end
        end
        else if (cmd.adv)
        begin
            pos_reg <= pos_next;
        end
        if (cmd.clr_step) mem[clr_reg] <= '0;
        else if (cmd.wr) mem[pos_reg] <= key_reg;
        if (cmd.rd) rd_reg <= mem[pos_reg];
        if (cmd.ld_out)
        begin
            st_reg     <= res_status;
            slot_reg   <= use_slot ? SLOT_W'(pos_reg) : '0;
            cntout_reg <= COUNT_W'(cnt_reg + (cmd.wr ? 1'b1 : 1'b0));
        end
    end

    assign sts.clr_done  = (clr_reg == AW'(TABLE_SIZE - 1));
    assign sts.red_done  = (dig_reg == DCW'(ND));
    assign sts.key_zero  = (key_reg == '0);
    assign sts.hit       = (rd_reg == key_reg);
    assign sts.empty     = (rd_reg == '0);
    assign sts.exhausted = (n_reg == CW'(TABLE_SIZE - 1));
    assign kind_q    = kind_reg;
    assign full_load = (64'(TABLE_SIZE) * 64'd80) <= (64'(cnt_reg) * 64'd100);
    assign out_status = st_reg;
    assign out_slot   = slot_reg;
    assign out_count  = cntout_reg;
endmodule
`default_nettype wire

@@ sv/dhks_ctrl.sv @@
`default_nettype none
module dhks_ctrl
    import dhks_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    output logic                     out_valid,
    input  wire logic                out_ready,
    input  wire dhks_sts_t           sts,
    input  wire logic                kind_q,
    input  wire logic                full_load,
    output dhks_cmd_t                cmd,
    output logic [STATUS_W-1:0]      res_status,
    output logic                     use_slot
);
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_RED   = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_CHECK = 3'd4;

    logic [2:0] state_reg, state_next;
    logic ov_reg, ov_next;

    // The result register is free again once it is taken, so a new request can enter.
    assign in_ready  = (state_reg == S_IDLE) && (!ov_reg || out_ready);
    assign out_valid = ov_reg;

    always_comb begin
        state_next = state_reg;
        ov_next = ov_reg && !out_ready;
        cmd = '0;
        res_status = ST_ABSENT;
        use_slot = 1'b0;
        case (state_reg)
            S_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (sts.clr_done) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (in_valid && in_ready) begin
                    cmd.start = 1'b1;
                    state_next = S_RED;
                end
            end
            S_RED: begin
                if (sts.red_done) begin
                    if (sts.key_zero) begin
                        cmd.ld_out = 1'b1;
                        res_status = kind_q ? ST_FULL : ST_ABSENT;
                        ov_next = 1'b1;
                        state_next = S_IDLE;
                    end else begin
                        cmd.rd = 1'b1;
                        state_next = S_CHECK;
                    end
                end else begin
                    cmd.red_step = 1'b1;
                end
            end
            S_READ: begin
                cmd.rd = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK: begin
                if (sts.empty || sts.hit) begin
                    cmd.ld_out = 1'b1;
                    use_slot = 1'b1;
                    ov_next = 1'b1;
                    state_next = S_IDLE;
                    if (!kind_q) res_status = sts.hit ? ST_FOUND : ST_ABSENT;
                    else if (sts.hit) res_status = ST_PRESENT;
                    else if (full_load) res_status = ST_FULL;
                    else begin
                        res_status = ST_INSERTED;
                        cmd.wr = 1'b1;
                    end
                end else if (sts.exhausted) begin
                    cmd.ld_out = 1'b1;
                    res_status = kind_q ? ST_FULL : ST_ABSENT;
                    ov_next = 1'b1;
                    state_next = S_IDLE;
                end else begin
                    cmd.adv = 1'b1;
                    state_next = S_READ;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= S_CLEAR;
            ov_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ov_reg <= ov_next;
        end
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ready) else $error("request taken while busy");
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !out_ready) |=> ov_reg) else $error("result dropped");
    a_write_only_insert: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr |-> (kind_q && sts.empty && !full_load)) else $error("bad write");
    a_clear_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR && sts.clr_done) |=> state_reg == S_IDLE)
        else $error("clear sweep did not end");
`endif
endmodule
`default_nettype wire

@@ sv/double_hash_key_set.sv @@
// Sequence: an accepted request reduces the key one 16-bit digit at a time, each digit
// in an estimate phase then a correction phase; a nonzero key then probes the table
// (read, then check, with an advance before each further probe) until the search ends.
// Throughput: one request at a time; no new request is accepted until the last one ends.
// Reset: asynchronous, active low; afterwards a sweep clears every table slot,
// during which no request is accepted.
`default_nettype none
module double_hash_key_set
    import dhks_pkg::*;
#(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF,
    parameter int KEY_WIDTH  = KEY_WIDTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,  // key[63:0]
    input  wire logic        s_tuser,  // kind
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata   // status[2:0], slot[12:3], count[22:13], zero
);
    dhks_cmd_t cmd;
    dhks_sts_t sts;
    logic [STATUS_W-1:0] res_status, out_status;
    logic [SLOT_W-1:0] out_slot;
    logic [COUNT_W-1:0] out_count;
    logic use_slot, kind_q, full_load;

    dhks_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .sts(sts), .kind_q(kind_q), .full_load(full_load),
        .cmd(cmd), .res_status(res_status), .use_slot(use_slot)
    );

    dhks_datapath #(.TABLE_SIZE(TABLE_SIZE), .KEY_WIDTH(KEY_WIDTH)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .in_kind(s_tuser), .in_key(s_tdata),
        .res_status(res_status), .use_slot(use_slot),
        .out_status(out_status), .out_slot(out_slot), .out_count(out_count),
        .kind_q(kind_q), .full_load(full_load)
    );

    assign m_tdata = {1'b0, out_count, out_slot, out_status};
endmodule
`default_nettype wire

@@ bench/double_hash_key_set_checker.sv @@
`default_nettype none
module double_hash_key_set_checker
    import dhks_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [63:0] s_tdata,
    input  wire logic        s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [23:0] m_tdata,
    output int               fail_count,
    output int               pending
);
    localparam int NSLOT = TABLE_SIZE_DEF;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [COUNT_W-1:0]  count;
    } lookup_reply_t;

    logic [63:0]   set_keys [NSLOT];
    int            key_total;
    lookup_reply_t reply_q[$];

    function automatic lookup_reply_t predict_reply(input logic do_insert, input logic [63:0] key);
        lookup_reply_t r;
        logic [63:0] k;
        logic [63:0] pos;
        logic [63:0] stride;
        int where;
        int outcome;
        where = 0;
        outcome = -1;
        if (key == 64'd0) begin
            r.status = do_insert ? ST_FULL : ST_ABSENT;
        end
        else begin
            k = key - 64'd1;
            pos = k % NSLOT;
            stride = 64'd1 + k % (NSLOT - 1);
            for (int n = 0; n < NSLOT && outcome < 0; n++) begin
                if (set_keys[pos] == 64'd0) begin
                    outcome = 0;
                    where = int'(pos);
                end
                else if (set_keys[pos] == key) begin
                    outcome = 1;
                    where = int'(pos);
                end
                else begin
                    pos = (pos + stride) % NSLOT;
                end
            end
            if (!do_insert) begin
                r.status = (outcome == 1) ? ST_FOUND : ST_ABSENT;
            end
            else if (outcome == 1) begin
                r.status = ST_PRESENT;
            end
            else if (outcome < 0 || NSLOT * 80 <= key_total * 100) begin
                r.status = ST_FULL;
            end
            else begin
                set_keys[where] = key;
                key_total++;
                r.status = ST_INSERTED;
            end
        end
        r.slot = where[SLOT_W-1:0];
        r.count = key_total[COUNT_W-1:0];
        return r;
    endfunction

    initial
    begin
        for (int i = 0; i < NSLOT; i++) set_keys[i] = '0;
        key_total = 0;
        fail_count = 0;
        pending = 0;
    end

    always @(posedge clk)
    begin
        lookup_reply_t got;
        lookup_reply_t want;
        if (s_tvalid && s_tready)
            reply_q.push_back(predict_reply(s_tuser, s_tdata));
        if (m_tvalid && m_tready) begin
            got.status = m_tdata[2:0];
            got.slot = m_tdata[12:3];
            got.count = m_tdata[22:13];
            if (reply_q.size() == 0) begin
                $display("%0t: unexpected reply, expected none, actual %h", $time, m_tdata);
                fail_count++;
            end
            else begin
                want = reply_q.pop_front();
                if (got.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
                    fail_count++;
                end
                if (got.slot !== want.slot) begin
                    $display("%0t: slot expected %0d actual %0d", $time, want.slot, got.slot);
                    fail_count++;
                end
                if (got.count !== want.count) begin
                    $display("%0t: count expected %0d actual %0d", $time, want.count, got.count);
                    fail_count++;
                end
            end
        end
        pending <= reply_q.size();
    end
endmodule
`default_nettype wire

@@ bench/double_hash_key_set_tb.sv @@
`default_nettype none
module double_hash_key_set_tb;

    localparam logic KIND_LOOKUP = 1'b0;
    localparam logic KIND_INSERT = 1'b1;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    int          fail_count;
    int          pending;
    int          sent;
    logic [63:0] used_keys[$];

    always #6 clk = ~clk;

    double_hash_key_set u_top (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    double_hash_key_set_checker u_chk (
        .clk(clk), .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fail_count(fail_count), .pending(pending)
    );

    // Valid stays high into the next request when no idle cycles are drawn.
    task automatic send_request(input logic kind, input logic [63:0] key);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= key;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
        sent++;
        if (kind == KIND_INSERT && key != 0) used_keys.push_back(key);
    endtask

    function automatic logic [63:0] rand_key();
        logic [63:0] k;
        case ($urandom_range(0, 5))
            0: k = {32'd0, 32'($urandom_range(1, 3000))};
            1: k = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 50));
            default: k = {$urandom, $urandom};
        endcase
        if (used_keys.size() > 0 && $urandom_range(0, 2) == 0)
            k = used_keys[$urandom_range(0, used_keys.size() - 1)];
        return k;
    endfunction

    // Receiver stalls a random number of cycles before each reply.
    initial
    begin
        int hold;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
            if (hold > 0)
            begin
                m_tready <= 1'b0;
                repeat (hold) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    initial
    begin
        sent = 0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        // Directed: zero keys, extremes, colliding keys, duplicates.
        send_request(KIND_LOOKUP, 64'd0);
        send_request(KIND_INSERT, 64'd0);
        send_request(KIND_LOOKUP, 64'd1);
        send_request(KIND_INSERT, 64'd1);
        send_request(KIND_INSERT, 64'd1);
        send_request(KIND_LOOKUP, 64'd1);
        send_request(KIND_INSERT, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(KIND_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(KIND_INSERT, 64'd1022);
        send_request(KIND_INSERT, 64'd2043);
        send_request(KIND_LOOKUP, 64'd2043);
        send_request(KIND_LOOKUP, 64'd3064);
        send_request(KIND_INSERT, 64'hAAAA_AAAA_AAAA_AAAA);
        send_request(KIND_INSERT, 64'h5555_5555_5555_5555);
        send_request(KIND_LOOKUP, 64'h8000_0000_0000_0000);
        s_tvalid <= 1'b0;
        wait (pending == 0);
        @(negedge clk);
        // Random phase: insert-heavy so the load limit is reached and tested.
        for (int i = 0; i < 1300; i++)
        begin
            send_request(($urandom_range(0, 9) < 7) ? KIND_INSERT : KIND_LOOKUP, rand_key());
            if (i == 600)
            begin
                s_tvalid <= 1'b0;
                wait (pending == 0);
                @(negedge clk);
            end
        end
        s_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (400) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("simulation failed");
        $finish;
    end
endmodule
`default_nettype wire
